FILE: rtl/yts_pkg.sv
// ----------------------------------------------------------------------------
// yts_pkg
// Shared types and constants of the yaw turn steering controller.
// ----------------------------------------------------------------------------
package yts_pkg;

    localparam int GAIN_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int THRESH_W    = 15;
    localparam int LOCK_W      = 16;
    localparam int MOTOR_W     = 6;
    localparam int CFG_INDEX_W = 3;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

    // Configuration register indexes
    localparam cfg_index_t REG_GAIN_P    = 3'd0;
    localparam cfg_index_t REG_GAIN_I    = 3'd1;
    localparam cfg_index_t REG_GAIN_D    = 3'd2;
    localparam cfg_index_t REG_THRESHOLD = 3'd3;
    localparam cfg_index_t REG_LOCK_NEG  = 3'd4;
    localparam cfg_index_t REG_LOCK_POS  = 3'd5;

    // Item opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_TURN = 1'b1;

    // Reset values of the registers
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 15'd640;   // 10 degrees
    localparam logic [LOCK_W-1:0]   LOCK_NEG_RESET  = 16'hF7AD;  // -2131, -33.3 degrees
    localparam logic [LOCK_W-1:0]   LOCK_POS_RESET  = 16'h0A20;  // 2592, 40.5 degrees

    // Wheel speed commands for a turn start
    localparam logic [MOTOR_W-1:0] MOTOR_FWD  = 6'd20;
    localparam logic [MOTOR_W-1:0] MOTOR_REV  = 6'h2C;           // -20
    localparam logic [MOTOR_W-1:0] MOTOR_NONE = 6'd0;

    typedef struct packed {
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i;
        logic [GAIN_W-1:0]   gain_d;
        logic [THRESH_W-1:0] threshold;
        logic [LOCK_W-1:0]   lock_neg;
        logic [LOCK_W-1:0]   lock_pos;
    } yts_cfg_t;

    typedef struct packed {
        logic valid;
        logic tick;
        logic coarse;
        logic reverse;
    } yts_ctrl_t;

endpackage

FILE: rtl/yts_item_if.sv
// ----------------------------------------------------------------------------
// yts_item_if
// Input channel: one control tick or turn start per transfer.
// ----------------------------------------------------------------------------
interface yts_item_if #(
    parameter int ANGLE_WIDTH = 16
);
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [ANGLE_WIDTH-1:0] measured_yaw;
    logic [ANGLE_WIDTH-1:0] turn_angle;
    logic                   turn_reverse;

    modport source (
        output valid, opcode, measured_yaw, turn_angle, turn_reverse,
        input  ready
    );
    modport sink (
        input  valid, opcode, measured_yaw, turn_angle, turn_reverse,
        output ready
    );
endinterface

FILE: rtl/yts_result_if.sv
// ----------------------------------------------------------------------------
// yts_result_if
// Result channel: servo or motor command, one per input transfer.
// ----------------------------------------------------------------------------
interface yts_result_if #(
    parameter int ANGLE_WIDTH = 16
);
    logic                   valid;
    logic                   ready;
    logic [ANGLE_WIDTH-1:0] servo_angle;
    logic                   servo_valid;
    logic [5:0]             motor_speed;
    logic                   motor_valid;

    modport source (
        output valid, servo_angle, servo_valid, motor_speed, motor_valid,
        input  ready
    );
    modport sink (
        input  valid, servo_angle, servo_valid, motor_speed, motor_valid,
        output ready
    );
endinterface

FILE: rtl/yts_cfg_regs.sv
// ----------------------------------------------------------------------------
// yts_cfg_regs
// Gain, threshold and lock angle registers behind the write port.
// ----------------------------------------------------------------------------
module yts_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  yts_pkg::cfg_index_t cfg_index,
    input  yts_pkg::cfg_data_t  cfg_data,
    output yts_pkg::yts_cfg_t   cfg
);
    import yts_pkg::*;

    yts_cfg_t cfg_reg;
    yts_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN_P:    cfg_next.gain_p    = cfg_data;
                REG_GAIN_I:    cfg_next.gain_i    = cfg_data;
                REG_GAIN_D:    cfg_next.gain_d    = cfg_data;
                REG_THRESHOLD: cfg_next.threshold = cfg_data[THRESH_W-1:0];
                REG_LOCK_NEG:  cfg_next.lock_neg  = cfg_data;
                REG_LOCK_POS:  cfg_next.lock_pos  = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p    <= '0;
            cfg_reg.gain_i    <= '0;
            cfg_reg.gain_d    <= '0;
            cfg_reg.threshold <= THRESHOLD_RESET;
            cfg_reg.lock_neg  <= LOCK_NEG_RESET;
            cfg_reg.lock_pos  <= LOCK_POS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/yts_err_stage.sv
// ----------------------------------------------------------------------------
// yts_err_stage
// Heading state, error, integral update and coarse/lock decision.
// ----------------------------------------------------------------------------
module yts_err_stage #(
    parameter int ANGLE_WIDTH = 16,
    parameter int SUM_WIDTH   = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   accept,
    input  logic                   opcode,
    input  logic [ANGLE_WIDTH-1:0] measured_yaw,
    input  logic [ANGLE_WIDTH-1:0] turn_angle,
    input  logic                   turn_reverse,
    input  yts_pkg::yts_cfg_t      cfg,
    output yts_pkg::yts_ctrl_t     s1_ctrl,
    output logic [ANGLE_WIDTH-1:0] s1_lock,
    output logic [ANGLE_WIDTH:0]   s1_err,
    output logic [SUM_WIDTH-1:0]   s1_sum,
    output logic [ANGLE_WIDTH+1:0] s1_diff
);
    import yts_pkg::*;

    localparam int AW = ANGLE_WIDTH;
    localparam int EW = AW + 1;
    localparam int DW = AW + 2;
    localparam int LW = ((AW > LOCK_W) ? AW : LOCK_W) + 1;
    localparam int CW = (EW > THRESH_W) ? EW : THRESH_W;
    localparam int XW = ((SUM_WIDTH > EW) ? SUM_WIDTH : EW) + 1;
    localparam int SW = SUM_WIDTH;

    localparam logic [AW-1:0] ANGLE_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic [AW-1:0] ANGLE_MIN = {1'b1, {(AW-1){1'b0}}};
    localparam logic [SW-1:0] SUM_MAX   = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SUM_MIN   = {1'b1, {(SW-1){1'b0}}};

    logic [AW-1:0] target_reg, target_next;
    logic          reverse_reg;
    logic [EW-1:0] prev_err_reg;
    logic [SW-1:0] sum_reg, sum_next;

    yts_ctrl_t     ctrl_reg;
    logic [AW-1:0] lock_reg;
    logic [EW-1:0] err_reg;
    logic [SW-1:0] sumo_reg;
    logic [DW-1:0] diff_reg;

    logic [EW-1:0] yaw_x, ang_x, tgt_x, turn_sum, err, mag;
    logic [DW-1:0] diff;
    logic [XW-1:0] sum_wide;
    logic [LW-1:0] lock_neg_x, lock_pos_x, lock_x;
    logic [AW-1:0] lock_sat;
    logic          coarse, err_pos, err_neg, use_neg;

    always_comb
    begin
        yaw_x = {measured_yaw[AW-1], measured_yaw};
        ang_x = {turn_angle[AW-1], turn_angle};
        tgt_x = {target_reg[AW-1], target_reg};

        // Turn start: saturate the new heading target
        turn_sum = yaw_x + ang_x;
        if (turn_sum[EW-1] == turn_sum[AW-1])
            target_next = turn_sum[AW-1:0];
        else if (turn_sum[EW-1])
            target_next = ANGLE_MIN;
        else
            target_next = ANGLE_MAX;

        // Control tick: exact error and its magnitude
        err     = yaw_x - tgt_x;
        mag     = err[EW-1] ? (~err + EW'(1)) : err;
        coarse  = (CW'(mag) > CW'(cfg.threshold));
        err_neg = err[EW-1];
        err_pos = !err[EW-1] && (|err);
        use_neg = (!reverse_reg && err_pos) || (reverse_reg && err_neg);

        lock_neg_x = {{(LW-LOCK_W){cfg.lock_neg[LOCK_W-1]}}, cfg.lock_neg};
        lock_pos_x = {{(LW-LOCK_W){cfg.lock_pos[LOCK_W-1]}}, cfg.lock_pos};
        lock_x     = use_neg ? lock_neg_x : lock_pos_x;
        if ((&lock_x[LW-1:AW-1]) || !(|lock_x[LW-1:AW-1]))
            lock_sat = lock_x[AW-1:0];
        else if (lock_x[LW-1])
            lock_sat = ANGLE_MIN;
        else
            lock_sat = ANGLE_MAX;

        diff = {err[EW-1], err} - {prev_err_reg[EW-1], prev_err_reg};

        // Saturating integral of the raw error
        sum_wide = {{(XW-SW){sum_reg[SW-1]}}, sum_reg} + {{(XW-EW){err[EW-1]}}, err};
        if ((&sum_wide[XW-1:SW-1]) || !(|sum_wide[XW-1:SW-1]))
            sum_next = sum_wide[SW-1:0];
        else if (sum_wide[XW-1])
            sum_next = SUM_MIN;
        else
            sum_next = SUM_MAX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= '0;
            reverse_reg  <= 1'b0;
            prev_err_reg <= '0;
            sum_reg      <= '0;
        end
        else if (accept)
        begin
            if (opcode == OP_TURN)
            begin
                target_reg  <= target_next;
                reverse_reg <= turn_reverse;
            end
            else
            begin
                prev_err_reg <= err;
                if (!coarse)
                    sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else if (en)
        begin
            ctrl_reg.valid   <= accept;
            ctrl_reg.tick    <= (opcode == OP_TICK);
            ctrl_reg.coarse  <= coarse;
            ctrl_reg.reverse <= turn_reverse;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lock_reg <= lock_sat;
            err_reg  <= err;
            sumo_reg <= sum_next;
            diff_reg <= diff;
        end
    end

    assign s1_ctrl = ctrl_reg;
    assign s1_lock = lock_reg;
    assign s1_err  = err_reg;
    assign s1_sum  = sumo_reg;
    assign s1_diff = diff_reg;

endmodule

FILE: rtl/yts_pid_datapath.sv
// ----------------------------------------------------------------------------
// yts_pid_datapath
// Gain products, Q8.8 rounding, output saturation and result register.
// ----------------------------------------------------------------------------
module yts_pid_datapath #(
    parameter int ANGLE_WIDTH = 16,
    parameter int SUM_WIDTH   = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  yts_pkg::yts_cfg_t      cfg,
    input  yts_pkg::yts_ctrl_t     s1_ctrl,
    input  logic [ANGLE_WIDTH-1:0] s1_lock,
    input  logic [ANGLE_WIDTH:0]   s1_err,
    input  logic [SUM_WIDTH-1:0]   s1_sum,
    input  logic [ANGLE_WIDTH+1:0] s1_diff,
    yts_result_if.source           result
);
    import yts_pkg::*;

    localparam int AW   = ANGLE_WIDTH;
    localparam int EW   = AW + 1;
    localparam int DW   = AW + 2;
    localparam int SW   = SUM_WIDTH;
    localparam int PW   = GAIN_W + EW;
    localparam int IW   = GAIN_W + SW;
    localparam int DPW  = GAIN_W + DW;
    localparam int ACCW = ((IW > DPW) ? IW : DPW) + 2;
    localparam int RW   = ACCW - 8;

    localparam logic [AW-1:0] ANGLE_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic [AW-1:0] ANGLE_MIN = {1'b1, {(AW-1){1'b0}}};
    localparam logic [ACCW-1:0] ROUND_HALF = ACCW'(128);

    yts_ctrl_t       ctrl2_reg;
    logic [AW-1:0]   lock2_reg;
    logic signed [PW-1:0]  p_reg;
    logic signed [IW-1:0]  i_reg;
    logic signed [DPW-1:0] d_reg;

    logic            valid_reg;
    logic [AW-1:0]   servo_angle_reg;
    logic            servo_valid_reg;
    logic [MOTOR_W-1:0] motor_speed_reg;
    logic            motor_valid_reg;

    logic [ACCW-1:0] acc;
    logic [RW-1:0]   q;
    logic [AW-1:0]   pid_sat, cmd;

    // Stage 2: three independent products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl2_reg <= '0;
        else if (en)
            ctrl2_reg <= s1_ctrl;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lock2_reg <= s1_lock;
            p_reg     <= $signed(cfg.gain_p) * $signed(s1_err);
            i_reg     <= $signed(cfg.gain_i) * $signed(s1_sum);
            d_reg     <= $signed(cfg.gain_d) * $signed(s1_diff);
        end
    end

    // Stage 3: sum, round half up, drop the Q8.8 fraction, saturate, or take the lock angle on a coarse tick
    always_comb
    begin
        acc = {{(ACCW-PW){p_reg[PW-1]}}, p_reg}
            + {{(ACCW-IW){i_reg[IW-1]}}, i_reg}
            + {{(ACCW-DPW){d_reg[DPW-1]}}, d_reg}
            + ROUND_HALF;
        q = acc[ACCW-1:8];
        if ((&q[RW-1:AW-1]) || !(|q[RW-1:AW-1]))
            pid_sat = q[AW-1:0];
        else if (q[RW-1])
            pid_sat = ANGLE_MIN;
        else
            pid_sat = ANGLE_MAX;
        cmd = ctrl2_reg.coarse ? lock2_reg : pid_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= ctrl2_reg.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            servo_angle_reg <= ctrl2_reg.tick ? cmd : '0;
            servo_valid_reg <= ctrl2_reg.tick;
            motor_valid_reg <= !ctrl2_reg.tick;
            if (ctrl2_reg.tick)
                motor_speed_reg <= MOTOR_NONE;
            else if (ctrl2_reg.reverse)
                motor_speed_reg <= MOTOR_REV;
            else
                motor_speed_reg <= MOTOR_FWD;
        end
    end

    assign result.valid       = valid_reg;
    assign result.servo_angle = servo_angle_reg;
    assign result.servo_valid = servo_valid_reg;
    assign result.motor_speed = motor_speed_reg;
    assign result.motor_valid = motor_valid_reg;

endmodule

FILE: rtl/yaw_turn_pid_steering.sv
// ----------------------------------------------------------------------------
// yaw_turn_pid_steering
// Turn steering controller: heading target, coarse lock angles, PID step.
// ----------------------------------------------------------------------------
// Takes one item per clock while the result side is not stalled and returns
// exactly one result per item, through the error, product and result
// registers. The heading target, previous error and integral are updated
// in the cycle an item is taken, so back-to-back ticks see each other's
// state; the gain products and the Q8.8 rounding follow in two further
// registered stages. All stages advance together whenever the result
// register is empty or being taken, so item.ready follows result.ready
// through one gate. Configuration writes take effect at once and are meant for an idle block.
module yaw_turn_pid_steering #(
    parameter int ANGLE_WIDTH = 16,
    parameter int SUM_WIDTH   = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  yts_pkg::cfg_index_t cfg_index,
    input  yts_pkg::cfg_data_t  cfg_data,
    yts_item_if.sink            item,
    yts_result_if.source        result
);
    import yts_pkg::*;

    yts_cfg_t               cfg;
    yts_ctrl_t              s1_ctrl;
    logic [ANGLE_WIDTH-1:0] s1_lock;
    logic [ANGLE_WIDTH:0]   s1_err;
    logic [SUM_WIDTH-1:0]   s1_sum;
    logic [ANGLE_WIDTH+1:0] s1_diff;
    logic                   en;
    logic                   accept;

    // Advance the pipe unless a finished result is held back
    assign en         = !result.valid || result.ready;
    assign item.ready = en;
    assign accept     = item.valid && en;

    yts_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    yts_err_stage #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .SUM_WIDTH   (SUM_WIDTH)
    ) u_err (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .accept       (accept),
        .opcode       (item.opcode),
        .measured_yaw (item.measured_yaw),
        .turn_angle   (item.turn_angle),
        .turn_reverse (item.turn_reverse),
        .cfg          (cfg),
        .s1_ctrl      (s1_ctrl),
        .s1_lock      (s1_lock),
        .s1_err       (s1_err),
        .s1_sum       (s1_sum),
        .s1_diff      (s1_diff)
    );

    yts_pid_datapath #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .SUM_WIDTH   (SUM_WIDTH)
    ) u_pid (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .cfg     (cfg),
        .s1_ctrl (s1_ctrl),
        .s1_lock (s1_lock),
        .s1_err  (s1_err),
        .s1_sum  (s1_sum),
        .s1_diff (s1_diff),
        .result  (result)
    );

endmodule

FILE: rtl/yts_checker.sv
// ----------------------------------------------------------------------------
// yts_checker
// Port-level checks on result form and flow control of the controller.
// ----------------------------------------------------------------------------
module yts_checker #(
    parameter int ANGLE_WIDTH = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   item_ready,
    input logic                   result_valid,
    input logic                   result_ready,
    input logic [ANGLE_WIDTH-1:0] servo_angle,
    input logic                   servo_valid,
    input logic [5:0]             motor_speed,
    input logic                   motor_valid
);
    import yts_pkg::*;

    // Every result carries exactly one kind of command
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (servo_valid ^ motor_valid))
        else $error("result is neither a servo nor a motor command");

    // Turn start result: wheel speed of plus or minus 20, servo left at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && motor_valid) |->
            (servo_angle == '0) && (motor_speed == MOTOR_FWD || motor_speed == MOTOR_REV))
        else $error("malformed turn start result");

    // Tick result never drives the motor
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && servo_valid) |-> (motor_speed == MOTOR_NONE))
        else $error("tick result carries a motor speed");

    // Input is taken exactly when the result side can move
    assert property (@(posedge clk) disable iff (!rst_n)
        item_ready == (!result_valid || result_ready))
        else $error("item ready does not follow result flow control");

    // Stalled result holds until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            result_valid && $stable(servo_angle) && $stable(motor_speed))
        else $error("stalled result changed");

endmodule

bind yaw_turn_pid_steering yts_checker #(
    .ANGLE_WIDTH (ANGLE_WIDTH)
) u_yts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .servo_angle  (result.servo_angle),
    .servo_valid  (result.servo_valid),
    .motor_speed  (result.motor_speed),
    .motor_valid  (result.motor_valid)
);
